>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the survival scan block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/bss_pkg.sv
// Types, constants and saturation helper for the bivariate survival scan.
`timescale 1ns / 1ps
package bss_pkg;

    typedef logic signed [31:0] q_t;

    localparam q_t Q_ONE = 32'sh4000_0000;
    localparam logic [8:0] SIZE_RESET = 9'd256;

    typedef struct packed {
        q_t   joint_prob;
        q_t   row_margin;
        q_t   col_margin;
        logic first_col;
        logic first_row;
        logic last_cell;
    } cell_t;

    typedef struct packed {
        q_t row_accum;
        q_t tail;
        q_t survival;
    } cell_result_t;

    function automatic q_t sat33(input logic signed [32:0] v);
        q_t r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> src/bss_cell.sv
// Per-cell arithmetic: row sum, first-row tail and saturated survival value.
`timescale 1ns / 1ps
module bss_cell
    import bss_pkg::*;
(
    input  cell_t        item,
    input  q_t           row_accum,
    input  q_t           tail,
    input  q_t           above_rd,
    output cell_result_t result
);

    logic signed [32:0] ra_sum;
    logic signed [32:0] tail_sum;
    logic signed [32:0] surv_sum;
    q_t                 ra_new;
    q_t                 tail_new;
    q_t                 above;

    always_comb begin
        if (item.first_col) begin
            ra_sum   = {item.joint_prob[31], item.joint_prob}
                     - {item.row_margin[31], item.row_margin};
            tail_sum = {Q_ONE[31], Q_ONE} - {item.col_margin[31], item.col_margin};
        end else begin
            ra_sum   = {row_accum[31], row_accum} + {item.joint_prob[31], item.joint_prob};
            tail_sum = {tail[31], tail} - {item.col_margin[31], item.col_margin};
        end
        ra_new   = sat33(ra_sum);
        tail_new = item.first_row ? sat33(tail_sum) : tail;
        above    = item.first_row ? tail_new : above_rd;
        surv_sum = {above[31], above} + {ra_new[31], ra_new};

        result.row_accum = ra_new;
        result.tail      = tail_new;
        result.survival  = sat33(surv_sum);
    end

endmodule

>>> src/bivariate_survival_scan_core.sv
// Top level of the bivariate survival scan: handshakes, position, line store.
`timescale 1ns / 1ps
// Streams a square joint probability table in row-major order and returns one
// survival value per cell. Each input item on the s_ channel carries the cell's
// joint probability, row marginal and column marginal; each result item on the
// m_ channel carries the survival value and, on m_tlast, the mark of the last
// cell of the table. The cfg_ channel sets the table size and restarts the
// position at the first cell; it is always ready. The user must see that it is
// written only while idle; the block itself does not enforce this. While the
// receiver takes results, one item is accepted every cycle: an input stage and an
// output register hold one item each, and the line store is read when an item
// enters and written when its result is formed, one access of each kind per cycle.
// When the receiver stalls, the result is held in the output register and one more
// item waits in the input stage; s_tready then drops. Reset empties both stages,
// clears the running sums and the position, and sets the size to its largest
// value. The line store is not cleared; row 0 of each table fills it.
`include "assert_macros.svh"
module bivariate_survival_scan_core
    import bss_pkg::*;
#(
    parameter int MAX_SIZE = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: joint_prob[31:0], row_margin[63:32], col_margin[95:64].
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: survival[31:0].
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);

    localparam int CNT_W = $clog2(MAX_SIZE);
    localparam int N_W   = CNT_W + 1;
    localparam int CMP_W = (N_W > 9) ? N_W : 9;

    function automatic logic [CNT_W-1:0] last_index(input logic [8:0] sz);
        logic [CMP_W-1:0] v;
        v = CMP_W'(sz);
        if (v == '0) begin
            v = CMP_W'(1);
        end
        if (v > CMP_W'(MAX_SIZE)) begin
            v = CMP_W'(MAX_SIZE);
        end
        return CNT_W'(v - CMP_W'(1));
    endfunction

    logic [CNT_W-1:0] last_idx_reg;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_next;
    logic [CNT_W-1:0] s1_col_reg;
    logic             s1_valid_reg;
    cell_t            s1_cell_reg;
    q_t               above_rd_reg;
    q_t               row_accum_reg;
    q_t               tail_reg;
    logic             m_valid_reg;
    q_t               m_surv_reg;
    logic             m_last_reg;
    q_t               line_mem [MAX_SIZE];
    cell_result_t     result;
    logic             accept;
    logic             advance;
    logic             at_last_col;
    logic             at_table_end;

    assign advance   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || advance;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign at_last_col  = (col_reg == last_idx_reg);
    assign at_table_end = at_last_col && (row_reg == last_idx_reg);

    always_comb begin
        col_next = at_last_col ? '0 : col_reg + CNT_W'(1);
        row_next = row_reg;
        if (at_last_col) begin
            row_next = (row_reg == last_idx_reg) ? '0 : row_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_idx_reg  <= last_index(SIZE_RESET);
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            row_accum_reg <= '0;
            tail_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                last_idx_reg <= last_index(cfg_data);
                col_reg      <= '0;
                row_reg      <= '0;
            end else if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg   <= 1'b1;
                row_accum_reg <= result.row_accum;
                tail_reg      <= result.tail;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cell_reg.joint_prob <= s_tdata[31:0];
            s1_cell_reg.row_margin <= s_tdata[63:32];
            s1_cell_reg.col_margin <= s_tdata[95:64];
            s1_cell_reg.first_col  <= (col_reg == '0);
            s1_cell_reg.first_row  <= (row_reg == '0);
            s1_cell_reg.last_cell  <= at_table_end;
            s1_col_reg             <= col_reg;
            above_rd_reg           <= line_mem[col_reg];
        end
        if (advance) begin
            line_mem[s1_col_reg] <= result.survival;
            m_surv_reg           <= result.survival;
            m_last_reg           <= s1_cell_reg.last_cell;
        end
    end

    bss_cell u_cell (
        .item      (s1_cell_reg),
        .row_accum (row_accum_reg),
        .tail      (tail_reg),
        .above_rd  (above_rd_reg),
        .result    (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_surv_reg;
    assign m_tlast  = m_last_reg;

    `ASSERT_IMPLIES(a_empty_stage_ready, aclk, aresetn, !s1_valid_reg, s_tready)
    `ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, m_tvalid)
    `ASSERT_IMPLIES(a_position_in_table, aclk, aresetn, 1'b1,
                    (col_reg <= last_idx_reg) && (row_reg <= last_idx_reg))
    `ASSERT_IMPLIES(a_last_at_end, aclk, aresetn, accept && at_table_end && !cfg_valid,
                    (col_next == '0) && (row_next == '0))

endmodule

>>> tb/bivariate_survival_scan_core_tb.sv
// Testbench for bivariate_survival_scan_core: random tables checked against a survival predictor.
`timescale 1ns / 1ps
module bivariate_survival_scan_core_tb
    import bss_pkg::*;
();

    localparam int TABLE_MAX = 256;
    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    typedef struct {
        q_t   survival;
        logic last_cell;
    } survival_exp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;

    logic [95:0]   cell_q[$];
    survival_exp_t survival_q[$];
    bit            hold_sender = 1'b0;
    int            send_idle_pct = 13;
    int            recv_idle_pct = 54;
    int            mismatches = 0;
    int            sent_total = 0;

    q_t         row_sum = '0;
    q_t         tail_sum = '0;
    q_t         line_mem[TABLE_MAX];
    int         cur_row = 0;
    int         cur_col = 0;
    logic [8:0] size_reg = SIZE_RESET;

    bivariate_survival_scan_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic q_t clamp_q(input longint v);
        q_t r;
        if (v > longint'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < longint'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = q_t'(v);
        end
        return r;
    endfunction

    function automatic int table_dim(input logic [8:0] sz);
        int n;
        n = int'(sz);
        if (n == 0) n = 1;
        if (n > TABLE_MAX) n = TABLE_MAX;
        return n;
    endfunction

    function automatic survival_exp_t predict_survival(input logic [95:0] item);
        q_t            jp;
        q_t            rm;
        q_t            cm;
        q_t            above;
        int            n;
        int            r;
        int            c;
        survival_exp_t e;
        jp = item[31:0];
        rm = item[63:32];
        cm = item[95:64];
        n = table_dim(size_reg);
        r = (cur_row >= n) ? 0 : cur_row;
        c = (cur_col >= n) ? 0 : cur_col;
        if (c == 0) begin
            row_sum = clamp_q(longint'(jp) - longint'(rm));
        end else begin
            row_sum = clamp_q(longint'(row_sum) + longint'(jp));
        end
        if (r == 0) begin
            if (c == 0) begin
                tail_sum = clamp_q(longint'(Q_ONE) - longint'(cm));
            end else begin
                tail_sum = clamp_q(longint'(tail_sum) - longint'(cm));
            end
            above = tail_sum;
        end else begin
            above = line_mem[c];
        end
        e.survival = clamp_q(longint'(above) + longint'(row_sum));
        e.last_cell = (r == n - 1) && (c == n - 1);
        line_mem[c] = e.survival;
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n) r = 0;
        end
        cur_row = r;
        cur_col = c;
        return e;
    endfunction

    function automatic q_t pick_value(input bit plausible, input int unsigned span);
        q_t v;
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
                0: v = Q_MAX;
                1: v = Q_MIN;
                2: v = Q_ONE;
                default: v = '0;
            endcase
        end else if (plausible) begin
            v = q_t'($urandom_range(0, span));
        end else begin
            v = q_t'($urandom());
        end
        return v;
    endfunction

    task automatic push_cell(input q_t jp, input q_t rm, input q_t cm);
        cell_q.push_back({cm, rm, jp});
        sent_total++;
    endtask

    task automatic wait_drained();
        while (!(cell_q.size() == 0 && !s_tvalid && survival_q.size() == 0)) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_table_size(input logic [8:0] v);
        wait_drained();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        size_reg = v;
        cur_row = 0;
        cur_col = 0;
    endtask

    task automatic run_table_phase(input logic [8:0] sz, input int count, input bit pressure);
        int          n;
        int unsigned cell_span;
        int unsigned margin_span;
        bit          plausible;
        n = table_dim(sz);
        cell_span = 32'h4000_0000 / (n * n);
        margin_span = 32'h4000_0000 / n;
        write_table_size(sz);
        for (int i = 0; i < count; i++) begin
            plausible = ($urandom_range(0, 99) < 75);
            push_cell(pick_value(plausible, cell_span), pick_value(plausible, margin_span),
                      pick_value(plausible, margin_span));
        end
        if (pressure) begin
            while (cell_q.size() > count / 2) @(posedge aclk);
            hold_sender <= 1'b1;
            @(posedge aclk);
            while (!(survival_q.size() == 0 && !s_tvalid)) @(posedge aclk);
            hold_sender <= 1'b0;
        end
    endtask

    // Sender: presents queued cells and runs the predictor on each accepted one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                survival_q.push_back(predict_survival(s_tdata));
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (cell_q.size() > 0 && !hold_sender &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= cell_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: compares each accepted result with the oldest expected one.
    always @(posedge aclk) begin : result_check
        survival_exp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (survival_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected item: survival=%h last_cell=%b", m_tdata, m_tlast);
                    end
                end else begin
                    e = survival_q.pop_front();
                    if (m_tdata !== e.survival || m_tlast !== e.last_cell) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: survival exp %h got %h, last_cell exp %b got %b",
                                     e.survival, m_tdata, e.last_cell, m_tlast);
                        end
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        int          phase;
        int          k;
        int          n;
        int          count;
        logic [8:0]  sz;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset size: the start of row 0 of the largest table.
        push_cell(Q_MAX, Q_MIN, Q_MIN);
        push_cell(Q_MIN, '0, Q_MAX);
        push_cell('0, '0, '0);
        push_cell(Q_ONE, Q_MAX, 32'sh1000_0000);

        // Size one: every cell is both first row and last cell.
        write_table_size(9'd1);
        push_cell(32'sh1000_0000, 32'sh2000_0000, 32'sh3000_0000);
        push_cell(Q_MIN, Q_MAX, Q_MIN);

        // Size zero behaves as size one.
        write_table_size(9'd0);
        push_cell(Q_MAX, Q_MIN, Q_MAX);
        push_cell(32'sh0100_0000, '0, 32'sh0200_0000);

        // Two whole 2x2 tables; the first one's ignored margins carry extreme values.
        write_table_size(9'd2);
        push_cell(32'sh1000_0000, 32'sh2000_0000, 32'sh2000_0000);
        push_cell(32'sh1000_0000, Q_MAX, 32'sh2000_0000);
        push_cell(32'sh1000_0000, 32'sh2000_0000, Q_MIN);
        push_cell(32'sh1000_0000, Q_MIN, Q_MAX);
        push_cell(Q_MAX, Q_MIN, Q_MIN);
        push_cell(Q_MAX, '0, Q_MAX);
        push_cell(Q_MIN, Q_MAX, '0);
        push_cell(Q_MIN, '0, Q_MIN);

        // A size write in the middle of a table restarts the position.
        write_table_size(9'd3);
        push_cell(32'sh0400_0000, 32'sh1000_0000, 32'sh1000_0000);
        push_cell(32'sh0400_0000, '0, 32'sh1000_0000);
        push_cell(32'sh0400_0000, '0, 32'sh1000_0000);
        push_cell(32'sh0400_0000, 32'sh1000_0000, '0);

        // Sizes above the largest table saturate.
        write_table_size(9'd511);
        push_cell(32'sh0000_1000, 32'sh0010_0000, 32'sh0010_0000);
        push_cell(Q_MIN, Q_MIN, Q_MAX);
        push_cell(Q_MAX, Q_MAX, Q_MIN);

        phase = 0;
        while (sent_total < 1050) begin
            if (sent_total < 350) begin
                send_idle_pct = 13;
                recv_idle_pct = 54;
            end else if (sent_total < 700) begin
                send_idle_pct = 54;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            k = $urandom_range(0, 19);
            case (k)
                0: sz = 9'd0;
                1: sz = 9'd511;
                2: sz = 9'd256;
                3: sz = 9'($urandom_range(0, 511));
                default: sz = 9'($urandom_range(1, 12));
            endcase
            n = table_dim(sz);
            if (n <= 12) begin
                count = n * n * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) count += $urandom_range(1, n * n);
            end else begin
                count = $urandom_range(20, 60);
            end
            if (count > 1050 - sent_total) count = 1050 - sent_total;
            run_table_phase(sz, count, (phase % 7) == 2);
            phase++;
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (survival_q.size() != 0) mismatches += survival_q.size();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/bss_pkg.sv
src/bss_cell.sv
src/bivariate_survival_scan_core.sv
tb/bivariate_survival_scan_core_tb.sv
